[rtl/rce_pkg.sv]
`default_nettype none

package rce_pkg;

    localparam int MAX_PAYLOAD_BYTES = 65536;
    localparam int MAX_COLUMNS       = 4096;

    localparam int POS_W   = 17;
    localparam int COL_W   = 12;
    localparam int VALUE_W = 64;
    localparam int FIELD_W = 16;

    localparam logic [POS_W-1:0] SAT17   = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PAYLOAD_BYTES + 1);

    localparam int SERIAL_VAR_BASE = 12;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HDRLEN = 4'b0001,
        PH_COLS   = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_ERR    = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        CL_NULL,
        CL_INT,
        CL_FLOAT,
        CL_CONST0,
        CL_CONST1,
        CL_BLOB,
        CL_TEXT,
        CL_ERR
    } t_class;

    typedef enum logic [2:0] {
        KIND_NULL  = 3'd0,
        KIND_INT   = 3'd1,
        KIND_FLOAT = 3'd2,
        KIND_BLOB  = 3'd3,
        KIND_TEXT  = 3'd4,
        KIND_ERROR = 3'd5
    } t_kind;

    typedef struct packed {
        t_class               cls;
        logic [FIELD_W-1:0]   offset;
        logic [FIELD_W-1:0]   length;
        logic [VALUE_W-1:0]   shifter;
    } t_summary;

endpackage

`default_nettype wire

[rtl/record_column_extractor.sv]
// Channel | Dir | Handshake   | Beat fields
// input   | in  | push / full | i_data_byte, i_last_byte
// result  | out | empty / pop | o_value_kind, o_int_value, o_content_offset, o_content_length
// config  | in  | i_cfg_we    | i_target_column
//
// One payload byte is taken every cycle while full is low; the header parser state is registered.
// The beat carrying the last byte places one result in a two-entry queue, and the result
// moves from the queue into the output register once that register is free.
// full rises only while the queue is full, that is when results are not popped.
// Reset is synchronous and active low; it clears the parser, the queue and the target column.
`default_nettype none

module record_column_extractor (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rce_pkg::COL_W-1:0]         i_target_column,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_last_byte,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [2:0]                             o_value_kind,
    output logic signed [rce_pkg::VALUE_W-1:0]     o_int_value,
    output logic [rce_pkg::FIELD_W-1:0]            o_content_offset,
    output logic [rce_pkg::FIELD_W-1:0]            o_content_length
);

    logic              beat;
    logic              front_done;
    rce_pkg::t_summary front_summary;
    logic              fifo_empty;
    rce_pkg::t_summary fifo_data;
    logic              back_take;

    assign beat = push && !full;

    rce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_target_column),
        .i_beat      (beat),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_done      (front_done),
        .o_summary   (front_summary)
    );

    rce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_done),
        .i_data  (front_summary),
        .i_pop   (back_take),
        .o_full  (full),
        .o_empty (fifo_empty),
        .o_data  (fifo_data)
    );

    rce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!fifo_empty),
        .i_summary        (fifo_data),
        .o_take           (back_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_value_kind     (o_value_kind),
        .o_int_value      (o_int_value),
        .o_content_offset (o_content_offset),
        .o_content_length (o_content_length)
    );

endmodule

`default_nettype wire

[rtl/rce_front.sv]
`default_nettype none

module rce_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rce_pkg::COL_W-1:0]      i_cfg_data,
    input  wire logic                           i_beat,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_last_byte,
    output logic                                o_done,
    output rce_pkg::t_summary                   o_summary
);

    localparam int PW = rce_pkg::POS_W;

    function automatic logic [PW-1:0] type_len(input logic [63:0] t);
        logic [63:0] d;
        logic [62:0] l;
        d = t - 64'(rce_pkg::SERIAL_VAR_BASE);
        l = d[63:1];
        if (t <= 64'd4) begin
            type_len = t[PW-1:0];
        end else if (t == 64'd5) begin
            type_len = PW'(6);
        end else if (t < 64'd8) begin
            type_len = PW'(8);
        end else if (t < 64'(rce_pkg::SERIAL_VAR_BASE)) begin
            type_len = '0;
        end else if (|l[62:PW]) begin
            type_len = rce_pkg::SAT17;
        end else begin
            type_len = l[PW-1:0];
        end
    endfunction

    function automatic rce_pkg::t_class classify(input logic [63:0] t);
        if (t == 64'd0) begin
            classify = rce_pkg::CL_NULL;
        end else if (t <= 64'd6) begin
            classify = rce_pkg::CL_INT;
        end else if (t == 64'd7) begin
            classify = rce_pkg::CL_FLOAT;
        end else if (t == 64'd8) begin
            classify = rce_pkg::CL_CONST0;
        end else if (t == 64'd9) begin
            classify = rce_pkg::CL_CONST1;
        end else if (t[0]) begin
            classify = rce_pkg::CL_TEXT;
        end else begin
            classify = rce_pkg::CL_BLOB;
        end
    endfunction

    logic [rce_pkg::COL_W-1:0] r_target, n_target;
    rce_pkg::t_phase           r_phase, n_phase;
    logic [PW-1:0]             r_pos, n_pos;
    logic [PW-1:0]             r_hdr, n_hdr;
    logic [63:0]               r_acc, n_acc;
    logic [3:0]                r_vcount, n_vcount;
    logic [rce_pkg::COL_W-1:0] r_col, n_col;
    logic [PW-1:0]             r_body, n_body;
    logic                      r_chosen, n_chosen;
    rce_pkg::t_class           r_cls, n_cls;
    logic [PW:0]               r_off, n_off;
    logic [PW-1:0]             r_len, n_len;
    logic [63:0]               r_shifter, n_shifter;

    logic [3:0]       vcount_inc;
    logic [3:0]       vcount_fed;
    logic [63:0]      acc_fed;
    logic             vdone;
    logic [PW:0]      pos_inc;
    rce_pkg::t_phase  phase_cur;
    logic [PW-1:0]    tlen;
    logic [PW-1:0]    hl;
    logic [PW:0]      body_sum;
    logic             chosen_now;
    logic [PW+1:0]    end_off;
    logic             ok;

    always_comb begin
        n_target  = i_cfg_we ? i_cfg_data : r_target;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_acc     = r_acc;
        n_vcount  = r_vcount;
        n_col     = r_col;
        n_body    = r_body;
        n_chosen  = r_chosen;
        n_cls     = r_cls;
        n_off     = r_off;
        n_len     = r_len;
        n_shifter = r_shifter;
        o_done    = 1'b0;
        o_summary = '0;
        chosen_now = r_chosen;

        vcount_inc = r_vcount + 4'd1;
        if (vcount_inc >= 4'd9) begin
            acc_fed    = {r_acc[55:0], i_data_byte};
            vdone      = 1'b1;
            vcount_fed = '0;
        end else begin
            acc_fed    = {r_acc[56:0], i_data_byte[6:0]};
            vdone      = ~i_data_byte[7];
            vcount_fed = vdone ? 4'd0 : vcount_inc;
        end
        tlen     = type_len(acc_fed);
        hl       = (|acc_fed[63:PW]) ? rce_pkg::SAT17 : acc_fed[PW-1:0];
        body_sum = {1'b0, r_body} + {1'b0, tlen};
        pos_inc  = {1'b0, r_pos} + 1'b1;

        phase_cur = (r_pos >= PW'(rce_pkg::MAX_PAYLOAD_BYTES)) ? rce_pkg::PH_ERR : r_phase;

        if (i_beat) begin
            unique case (phase_cur)
                rce_pkg::PH_HDRLEN: begin
                    n_acc    = acc_fed;
                    n_vcount = vcount_fed;
                    if (vdone) begin
                        n_acc = '0;
                        if ({1'b0, hl} <= pos_inc) begin
                            n_phase = rce_pkg::PH_ERR;
                        end else begin
                            n_hdr   = hl;
                            n_phase = rce_pkg::PH_COLS;
                        end
                    end
                end
                rce_pkg::PH_COLS: begin
                    n_acc    = acc_fed;
                    n_vcount = vcount_fed;
                    if (vdone) begin
                        n_acc = '0;
                        if (!r_chosen && (int'(r_col) < rce_pkg::MAX_COLUMNS)) begin
                            if (acc_fed == 64'd10 || acc_fed == 64'd11) begin
                                n_phase = rce_pkg::PH_ERR;
                            end else if (r_col == r_target) begin
                                n_chosen   = 1'b1;
                                chosen_now = 1'b1;
                                n_cls      = classify(acc_fed);
                                n_off      = {1'b0, r_hdr} + {1'b0, r_body};
                                n_len      = tlen;
                            end else begin
                                n_body = body_sum[PW] ? rce_pkg::SAT17 : body_sum[PW-1:0];
                                n_col  = r_col + 1'b1;
                            end
                        end
                    end
                    if (n_phase == rce_pkg::PH_COLS && pos_inc == {1'b0, r_hdr}) begin
                        if (vcount_fed != 4'd0) begin
                            n_phase = rce_pkg::PH_ERR;
                        end else begin
                            n_phase = chosen_now ? rce_pkg::PH_BODY : rce_pkg::PH_ERR;
                        end
                    end
                end
                rce_pkg::PH_BODY: begin
                    if ({1'b0, r_pos} >= r_off &&
                        {2'b0, r_pos} < ({1'b0, r_off} + {2'b0, r_len})) begin
                        n_shifter = {r_shifter[55:0], i_data_byte};
                    end
                end
                rce_pkg::PH_ERR: begin
                    n_phase = rce_pkg::PH_ERR;
                end
                default: begin
                    n_phase = rce_pkg::PH_ERR;
                end
            endcase

            if (r_pos < rce_pkg::POS_SAT) begin
                n_pos = pos_inc[PW-1:0];
            end

            if (i_last_byte) begin
                end_off = {1'b0, n_off} + {2'b0, n_len};
                ok      = (n_phase == rce_pkg::PH_BODY) && (end_off <= {2'b0, n_pos});
                o_done  = 1'b1;
                o_summary.cls     = ok ? n_cls : rce_pkg::CL_ERR;
                o_summary.offset  = ok ? n_off[rce_pkg::FIELD_W-1:0] : '0;
                o_summary.length  = ok ? n_len[rce_pkg::FIELD_W-1:0] : '0;
                o_summary.shifter = n_shifter;

                n_phase   = rce_pkg::PH_HDRLEN;
                n_pos     = '0;
                n_hdr     = '0;
                n_acc     = '0;
                n_vcount  = '0;
                n_col     = '0;
                n_body    = '0;
                n_chosen  = 1'b0;
                n_cls     = rce_pkg::CL_NULL;
                n_off     = '0;
                n_len     = '0;
                n_shifter = '0;
            end else begin
                end_off = '0;
                ok      = 1'b0;
            end
        end else begin
            end_off = '0;
            ok      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_phase   <= rce_pkg::PH_HDRLEN;
            r_pos     <= '0;
            r_hdr     <= '0;
            r_acc     <= '0;
            r_vcount  <= '0;
            r_col     <= '0;
            r_body    <= '0;
            r_chosen  <= 1'b0;
            r_cls     <= rce_pkg::CL_NULL;
            r_off     <= '0;
            r_len     <= '0;
            r_shifter <= '0;
        end else begin
            r_target  <= n_target;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_acc     <= n_acc;
            r_vcount  <= n_vcount;
            r_col     <= n_col;
            r_body    <= n_body;
            r_chosen  <= n_chosen;
            r_cls     <= n_cls;
            r_off     <= n_off;
            r_len     <= n_len;
            r_shifter <= n_shifter;
        end
    end

endmodule

`default_nettype wire

[rtl/rce_fifo.sv]
`default_nettype none

module rce_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rce_pkg::t_summary i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output rce_pkg::t_summary      o_data
);

    localparam int PTR_W = rce_pkg::FIFO_PTR_W;
    localparam int CNT_W = rce_pkg::FIFO_CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rce_pkg::FIFO_DEPTH - 1);

    rce_pkg::t_summary r_mem [rce_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(rce_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/rce_back.sv]
`default_nettype none

module rce_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire rce_pkg::t_summary                 i_summary,
    output logic                                   o_take,
    input  wire logic                              i_pop,
    output logic                                   o_empty,
    output logic [2:0]                             o_value_kind,
    output logic signed [rce_pkg::VALUE_W-1:0]     o_int_value,
    output logic [rce_pkg::FIELD_W-1:0]            o_content_offset,
    output logic [rce_pkg::FIELD_W-1:0]            o_content_length
);

    function automatic logic [63:0] sign_extend(input logic [63:0] s, input logic [3:0] n);
        unique case (n)
            4'd1:    sign_extend = {{56{s[7]}},  s[7:0]};
            4'd2:    sign_extend = {{48{s[15]}}, s[15:0]};
            4'd3:    sign_extend = {{40{s[23]}}, s[23:0]};
            4'd4:    sign_extend = {{32{s[31]}}, s[31:0]};
            4'd6:    sign_extend = {{16{s[47]}}, s[47:0]};
            default: sign_extend = s;
        endcase
    endfunction

    logic               r_valid, n_valid;
    rce_pkg::t_kind     r_kind, n_kind;
    logic [63:0]        r_value, n_value;
    logic [rce_pkg::FIELD_W-1:0] r_off, n_off;
    logic [rce_pkg::FIELD_W-1:0] r_len, n_len;

    assign o_take = i_valid && (!r_valid || i_pop);

    always_comb begin
        n_value = '0;
        n_off   = i_summary.offset;
        n_len   = i_summary.length;
        unique case (i_summary.cls)
            rce_pkg::CL_NULL: begin
                n_kind = rce_pkg::KIND_NULL;
            end
            rce_pkg::CL_INT: begin
                n_kind  = rce_pkg::KIND_INT;
                n_value = sign_extend(i_summary.shifter, i_summary.length[3:0]);
            end
            rce_pkg::CL_FLOAT: begin
                n_kind  = rce_pkg::KIND_FLOAT;
                n_value = i_summary.shifter;
            end
            rce_pkg::CL_CONST0: begin
                n_kind = rce_pkg::KIND_INT;
            end
            rce_pkg::CL_CONST1: begin
                n_kind  = rce_pkg::KIND_INT;
                n_value = 64'd1;
            end
            rce_pkg::CL_BLOB: begin
                n_kind = rce_pkg::KIND_BLOB;
            end
            rce_pkg::CL_TEXT: begin
                n_kind = rce_pkg::KIND_TEXT;
            end
            default: begin
                n_kind = rce_pkg::KIND_ERROR;
                n_off  = '0;
                n_len  = '0;
            end
        endcase

        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_off   <= n_off;
            r_len   <= n_len;
        end
    end

    assign o_empty          = !r_valid;
    assign o_value_kind     = r_kind;
    assign o_int_value      = r_value;
    assign o_content_offset = r_off;
    assign o_content_length = r_len;

endmodule

`default_nettype wire
